// ===== rtl/mroe_pkg.sv =====
package mroe_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int SIZE_W = 5;
  localparam int CMD_W  = 3;
  localparam int FRAC_W = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCALE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd4;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } alu_res_t;

endpackage

// ===== rtl/matrix_row_operation_engine.sv =====
// Matrix row operation engine: a square matrix of signed Q16.16 elements with
// load, read, scale row, add scaled row and swap rows commands.
// Command channel: drive in_* with start high; the command transfers at a
// clock edge where start is high and busy is low. Every command gives
// exactly one result on out_* marked by out_valid for a single cycle; the
// receiver cannot stall it and must take it in that cycle.
// Configuration: cfg_we writes cfg_matrix_size (rows and columns in use,
// capped at MAX_DIM); write it only while busy is low and no result is due.
// Path from transfer to result, by command:
//   load, rejected or unused command: result registered at the transfer, next command the cycle after
//   read: the registered memory read, then the registered result
//   scale, add scaled row: one column per cycle through the memory read,
//   the registered multiplier and the saturating adder to the write port
//   swap: two writes per column share the single write port
// Reset (rst_n low, synchronous) returns to idle with size 4; the matrix
// contents are not cleared and must be loaded before they are read.
module matrix_row_operation_engine #(
  parameter int MAX_DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [mroe_pkg::CMD_W-1:0]  in_command,
  input  logic        [mroe_pkg::IDX_W-1:0]  in_row_a,
  input  logic        [mroe_pkg::IDX_W-1:0]  in_row_b,
  input  logic        [mroe_pkg::IDX_W-1:0]  in_column,
  input  logic signed [mroe_pkg::DATA_W-1:0] in_scalar,
  input  logic signed [mroe_pkg::DATA_W-1:0] in_element_in,
  input  logic                               cfg_we,
  input  logic        [mroe_pkg::SIZE_W-1:0] cfg_matrix_size,
  output logic                               out_valid,
  output logic signed [mroe_pkg::DATA_W-1:0] out_element_out,
  output logic                               out_status,
  output logic                               out_saturated
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                               mem_we;
  logic        [AW-1:0]               mem_waddr;
  logic        [mroe_pkg::DATA_W-1:0] mem_wdata;
  logic        [AW-1:0]               mem_raddr_a;
  logic        [AW-1:0]               mem_raddr_b;
  logic        [mroe_pkg::DATA_W-1:0] mem_rdata_a;
  logic        [mroe_pkg::DATA_W-1:0] mem_rdata_b;
  logic signed [mroe_pkg::DATA_W-1:0] alu_scalar;
  logic                               alu_sel_b;
  mroe_pkg::alu_res_t                 alu_res;

  mroe_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  mroe_alu u_alu (
    .clk    (clk),
    .sel_b  (alu_sel_b),
    .scalar (alu_scalar),
    .d_a    (mem_rdata_a),
    .d_b    (mem_rdata_b),
    .res    (alu_res)
  );

  mroe_seq #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_row_a        (in_row_a),
    .in_row_b        (in_row_b),
    .in_column       (in_column),
    .in_scalar       (in_scalar),
    .in_element_in   (in_element_in),
    .cfg_we          (cfg_we),
    .cfg_matrix_size (cfg_matrix_size),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr_a     (mem_raddr_a),
    .mem_raddr_b     (mem_raddr_b),
    .mem_rdata_a     (mem_rdata_a),
    .mem_rdata_b     (mem_rdata_b),
    .alu_scalar      (alu_scalar),
    .alu_sel_b       (alu_sel_b),
    .alu_res         (alu_res),
    .out_valid       (out_valid),
    .out_element_out (out_element_out),
    .out_status      (out_status),
    .out_saturated   (out_saturated)
  );

endmodule

// ===== rtl/mroe_mem.sv =====
module mroe_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mroe_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr_a,
  input  logic [AW-1:0]               raddr_b,
  output logic [mroe_pkg::DATA_W-1:0] rdata_a,
  output logic [mroe_pkg::DATA_W-1:0] rdata_b
);

  // two copies written together give two read ports
  logic [mroe_pkg::DATA_W-1:0] bank_a [0:DEPTH-1];
  logic [mroe_pkg::DATA_W-1:0] bank_b [0:DEPTH-1];
  logic [mroe_pkg::DATA_W-1:0] rdata_a_r;
  logic [mroe_pkg::DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      bank_a[waddr] <= wdata;
      bank_b[waddr] <= wdata;
    end
    rdata_a_r <= bank_a[raddr_a];
    rdata_b_r <= bank_b[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/mroe_alu.sv =====
module mroe_alu (
  input  logic                               clk,
  input  logic                               sel_b,
  input  logic signed [mroe_pkg::DATA_W-1:0] scalar,
  input  logic        [mroe_pkg::DATA_W-1:0] d_a,
  input  logic        [mroe_pkg::DATA_W-1:0] d_b,
  output mroe_pkg::alu_res_t                 res
);

  logic signed [mroe_pkg::DATA_W-1:0]   opnd;
  logic signed [2*mroe_pkg::DATA_W-1:0] prod_r;
  logic        [mroe_pkg::DATA_W-1:0]   acc_r;
  logic                                 p_ovf;
  logic        [mroe_pkg::DATA_W-1:0]   p_val;
  logic        [mroe_pkg::DATA_W:0]     sum;
  logic                                 s_ovf;
  logic        [mroe_pkg::DATA_W-1:0]   s_val;

  assign opnd = sel_b ? d_b : d_a;

  always_ff @(posedge clk) begin
    prod_r <= scalar * opnd;
    acc_r  <= d_a;
  end

  // dropping the low fraction bits is a floor; bits above bit 47 must be a sign extension
  assign p_ovf = prod_r[63:47] != {17{prod_r[47]}};
  assign p_val = p_ovf ? (prod_r[63] ? mroe_pkg::Q_MIN : mroe_pkg::Q_MAX)
                       : prod_r[47:16];

  assign sum   = {p_val[31], p_val} + {acc_r[31], acc_r};
  assign s_ovf = sum[32] != sum[31];
  assign s_val = s_ovf ? (sum[32] ? mroe_pkg::Q_MIN : mroe_pkg::Q_MAX) : sum[31:0];

  assign res.value = sel_b ? s_val : p_val;
  assign res.sat   = p_ovf | (sel_b & s_ovf);

endmodule

// ===== rtl/mroe_seq.sv =====
module mroe_seq #(
  parameter int MAX_DIM = 16,
  parameter int AW      = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [mroe_pkg::CMD_W-1:0]  in_command,
  input  logic        [mroe_pkg::IDX_W-1:0]  in_row_a,
  input  logic        [mroe_pkg::IDX_W-1:0]  in_row_b,
  input  logic        [mroe_pkg::IDX_W-1:0]  in_column,
  input  logic signed [mroe_pkg::DATA_W-1:0] in_scalar,
  input  logic signed [mroe_pkg::DATA_W-1:0] in_element_in,
  input  logic                               cfg_we,
  input  logic        [mroe_pkg::SIZE_W-1:0] cfg_matrix_size,
  output logic                               mem_we,
  output logic        [AW-1:0]               mem_waddr,
  output logic        [mroe_pkg::DATA_W-1:0] mem_wdata,
  output logic        [AW-1:0]               mem_raddr_a,
  output logic        [AW-1:0]               mem_raddr_b,
  input  logic        [mroe_pkg::DATA_W-1:0] mem_rdata_a,
  input  logic        [mroe_pkg::DATA_W-1:0] mem_rdata_b,
  output logic signed [mroe_pkg::DATA_W-1:0] alu_scalar,
  output logic                               alu_sel_b,
  input  mroe_pkg::alu_res_t                 alu_res,
  output logic                               out_valid,
  output logic signed [mroe_pkg::DATA_W-1:0] out_element_out,
  output logic                               out_status,
  output logic                               out_saturated
);

  localparam int SW = mroe_pkg::SIZE_W;
  localparam int IW = mroe_pkg::IDX_W;
  localparam int DW = mroe_pkg::DATA_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                               input logic [SW-1:0] c);
    cell_addr = AW'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  logic [1:0]                  state_r, state_nxt;
  logic [mroe_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IW-1:0]               ra_r, ra_nxt;
  logic [IW-1:0]               rb_r, rb_nxt;
  logic [SW-1:0]               n_r, n_nxt;
  logic [SW-1:0]               m_r, m_nxt;
  logic signed [DW-1:0]        k_r, k_nxt;
  logic                        phase_r, phase_nxt;
  logic                        v1_r, v2_r, hold_v_r;
  logic [SW-1:0]               m1_r, m2_r, hold_m_r;
  logic [DW-1:0]               hold_d_r;
  logic                        sat_r, sat_nxt;
  logic [SW-1:0]               cfg_size_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [DW-1:0]               out_element_r, out_element_nxt;
  logic                        out_status_r, out_status_nxt;
  logic                        out_saturated_r, out_saturated_nxt;

  logic          accept;
  logic [SW-1:0] n_cur;
  logic          ra_ok, rb_ok, col_ok;
  logic          issue, last;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = state_r != ST_IDLE;

  assign n_cur  = (32'(cfg_size_r) > MAX_DIM) ? SW'(MAX_DIM) : cfg_size_r;
  assign ra_ok  = {1'b0, in_row_a} < n_cur;
  assign rb_ok  = {1'b0, in_row_b} < n_cur;
  assign col_ok = {1'b0, in_column} < n_cur;

  // swap issues reads only while phase_r is low so its two writes per column share the port
  assign issue = (state_r == ST_RUN) && ((cmd_r != mroe_pkg::CMD_SWAP) || !phase_r);
  assign last  = issue && (m_r == n_r - SW'(1));

  assign mem_raddr_a = (state_r == ST_IDLE) ? cell_addr(in_row_a, {1'b0, in_column})
                                            : cell_addr(ra_r, m_r);
  assign mem_raddr_b = cell_addr(rb_r, m_r);

  assign alu_scalar = k_r;
  assign alu_sel_b  = cmd_r == mroe_pkg::CMD_ADD;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(ra_r, m2_r);
    mem_wdata = alu_res.value;
    if (accept && (in_command == mroe_pkg::CMD_LOAD) && ra_ok && col_ok) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(in_row_a, {1'b0, in_column});
      mem_wdata = in_element_in;
    end else if (v2_r) begin
      mem_we = 1'b1;
    end else if (v1_r && (cmd_r == mroe_pkg::CMD_SWAP)) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(ra_r, m1_r);
      mem_wdata = mem_rdata_b;
    end else if (hold_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(rb_r, hold_m_r);
      mem_wdata = hold_d_r;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    ra_nxt            = ra_r;
    rb_nxt            = rb_r;
    n_nxt             = n_r;
    m_nxt             = m_r;
    k_nxt             = k_r;
    phase_nxt         = phase_r;
    sat_nxt           = sat_r;
    out_valid_nxt     = 1'b0;
    out_element_nxt   = '0;
    out_status_nxt    = 1'b0;
    out_saturated_nxt = 1'b0;

    if (v2_r) begin
      sat_nxt = sat_r | alu_res.sat;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          ra_nxt    = in_row_a;
          rb_nxt    = in_row_b;
          k_nxt     = in_scalar;
          n_nxt     = n_cur;
          m_nxt     = '0;
          phase_nxt = 1'b0;
          sat_nxt   = 1'b0;
          unique case (in_command) inside
            mroe_pkg::CMD_LOAD: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = !(ra_ok && col_ok);
            end
            mroe_pkg::CMD_READ: begin
              if (ra_ok && col_ok) begin
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            mroe_pkg::CMD_SCALE: begin
              if (ra_ok) begin
                state_nxt = ST_RUN;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            mroe_pkg::CMD_ADD, mroe_pkg::CMD_SWAP: begin
              if (ra_ok && rb_ok) begin
                state_nxt = ST_RUN;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt   = 1'b1;
        out_element_nxt = mem_rdata_a;
        state_nxt       = ST_IDLE;
      end
      ST_RUN: begin
        phase_nxt = ~phase_r;
        if (issue) begin
          m_nxt = m_r + SW'(1);
        end
        if (last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !hold_v_r) begin
          out_valid_nxt     = 1'b1;
          out_saturated_nxt = sat_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_size_r  <= mroe_pkg::SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r && (cmd_r != mroe_pkg::CMD_SWAP);
      hold_v_r    <= v1_r && (cmd_r == mroe_pkg::CMD_SWAP);
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_size_r <= cfg_matrix_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    ra_r            <= ra_nxt;
    rb_r            <= rb_nxt;
    n_r             <= n_nxt;
    m_r             <= m_nxt;
    k_r             <= k_nxt;
    phase_r         <= phase_nxt;
    sat_r           <= sat_nxt;
    m1_r            <= m_r;
    m2_r            <= m1_r;
    hold_m_r        <= m1_r;
    hold_d_r        <= mem_rdata_a;
    out_element_r   <= out_element_nxt;
    out_status_r    <= out_status_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_element_out = out_element_r;
  assign out_status      = out_status_r;
  assign out_saturated   = out_saturated_r;

endmodule

// ===== rtl/mroe_chk.sv =====
module mroe_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [mroe_pkg::DATA_W-1:0] out_element_out,
  input logic                               out_status,
  input logic                               out_saturated
);

  // a transferred command either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("command transfer neither started work nor gave a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // work only ends with a result
  a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_element_out == '0) && !out_saturated)
    else $error("rejected command carries data or saturation");

endmodule

bind matrix_row_operation_engine mroe_chk u_chk (.*);

// ===== sim/tb.sv =====
module tb;

  localparam int CMD_W  = mroe_pkg::CMD_W;
  localparam int IDX_W  = mroe_pkg::IDX_W;
  localparam int SIZE_W = mroe_pkg::SIZE_W;
  localparam int DATA_W = mroe_pkg::DATA_W;
  localparam int FRAC_W = mroe_pkg::FRAC_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = mroe_pkg::SIZE_RESET;

  localparam logic [CMD_W-1:0] CMD_LOAD  = mroe_pkg::CMD_LOAD;
  localparam logic [CMD_W-1:0] CMD_READ  = mroe_pkg::CMD_READ;
  localparam logic [CMD_W-1:0] CMD_SCALE = mroe_pkg::CMD_SCALE;
  localparam logic [CMD_W-1:0] CMD_ADD   = mroe_pkg::CMD_ADD;
  localparam logic [CMD_W-1:0] CMD_SWAP  = mroe_pkg::CMD_SWAP;

  localparam logic [DATA_W-1:0] Q_MAX = mroe_pkg::Q_MAX;
  localparam logic [DATA_W-1:0] Q_MIN = mroe_pkg::Q_MIN;

  localparam int DIM = 16;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_SWAP + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] Q_TWO     = 32'h0002_0000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  ra;
    logic [IDX_W-1:0]  rb;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] elem;
  } row_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              status;
    logic              sat;
  } row_res_t;

  typedef struct packed {
    row_cmd_t c;
    logic     typed;
    row_res_t r;
  } dir_step_t;

  localparam row_res_t R_DONE  = '{32'd0, ST_DONE, 1'b0};
  localparam row_res_t R_RANGE = '{32'd0, ST_RANGE, 1'b0};
  localparam row_res_t R_SAT   = '{32'd0, ST_DONE, 1'b1};

  // directed steps run at the reset size of four
  localparam int DIR_N = 25;
  localparam dir_step_t DIR_STEPS [DIR_N] = '{
    '{'{CMD_LOAD,  4'd0,  4'd0, 4'd0,  32'd0,     Q_MAX},         1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd0,  4'd0, 4'd1,  32'd0,     Q_MIN},         1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd0,  4'd0, 4'd2,  32'd0,     Q_ONE},         1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd0,  4'd0, 4'd3,  32'd0,     Q_NEG_ONE},     1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd1,  4'd0, 4'd0,  32'd0,     Q_TWO},         1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd1,  4'd0, 4'd1,  32'd0,     32'h0000_8000}, 1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd1,  4'd0, 4'd2,  32'd0,     32'hFFFF_FFFF}, 1'b1, R_DONE},
    '{'{CMD_LOAD,  4'd1,  4'd0, 4'd3,  32'd0,     32'h1234_5678}, 1'b1, R_DONE},
    '{'{CMD_READ,  4'd0,  4'd0, 4'd0,  32'd0,     32'd0},         1'b1,
      '{Q_MAX, ST_DONE, 1'b0}},
    '{'{CMD_READ,  4'd0,  4'd0, 4'd1,  32'd0,     32'd0},         1'b1,
      '{Q_MIN, ST_DONE, 1'b0}},
    '{'{CMD_LOAD,  4'd4,  4'd0, 4'd0,  32'd0,     Q_MAX},         1'b1, R_RANGE},
    '{'{CMD_READ,  4'd0,  4'd0, 4'd4,  32'd0,     32'd0},         1'b1, R_RANGE},
    '{'{CMD_LOAD,  4'd15, 4'd0, 4'd15, 32'd0,     Q_MIN},         1'b1, R_RANGE},
    // twice the largest element saturates
    '{'{CMD_SCALE, 4'd0,  4'd0, 4'd0,  Q_TWO,     32'd0},         1'b1, R_SAT},
    '{'{CMD_ADD,   4'd1,  4'd0, 4'd0,  Q_NEG_ONE, 32'd0},         1'b0, R_DONE},
    '{'{CMD_ADD,   4'd1,  4'd1, 4'd0,  Q_ONE,     32'd0},         1'b0, R_DONE},
    '{'{CMD_SWAP,  4'd0,  4'd1, 4'd0,  32'd0,     32'd0},         1'b1, R_DONE},
    '{'{CMD_SWAP,  4'd1,  4'd1, 4'd0,  32'd0,     32'd0},         1'b1, R_DONE},
    '{'{CMD_SCALE, 4'd1,  4'd0, 4'd0,  Q_MIN,     32'd0},         1'b0, R_DONE},
    '{'{CMD_READ,  4'd1,  4'd0, 4'd3,  32'd0,     32'd0},         1'b0, R_DONE},
    '{'{CMD_SCALE, 4'd4,  4'd0, 4'd0,  Q_ONE,     32'd0},         1'b1, R_RANGE},
    '{'{CMD_ADD,   4'd0,  4'd15, 4'd0, Q_ONE,     32'd0},         1'b1, R_RANGE},
    '{'{CMD_SWAP,  4'd5,  4'd0, 4'd0,  32'd0,     32'd0},         1'b1, R_RANGE},
    '{'{CMD_UNUSED_LO, 4'd0, 4'd1, 4'd2, Q_TWO,   Q_MAX},         1'b1, R_DONE},
    '{'{CMD_UNUSED_HI, 4'd15, 4'd15, 4'd15, Q_MIN, Q_MIN},        1'b1, R_DONE}
  };

  localparam int PHASES = 10;
  localparam logic [SIZE_W-1:0] PHASE_SIZE [PHASES] = '{
    5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd16, 5'd2, 5'd20, 5'd9, 5'd16
  };
  localparam int PHASE_ITEMS = 65;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [CMD_W-1:0]           in_command;
  logic [IDX_W-1:0]           in_row_a;
  logic [IDX_W-1:0]           in_row_b;
  logic [IDX_W-1:0]           in_column;
  logic signed [DATA_W-1:0]   in_scalar;
  logic signed [DATA_W-1:0]   in_element_in;
  logic                       cfg_we;
  logic [SIZE_W-1:0]          cfg_matrix_size;
  logic                       out_valid;
  logic signed [DATA_W-1:0]   out_element_out;
  logic                       out_status;
  logic                       out_saturated;

  logic [DATA_W-1:0] shadow_matrix [DIM*DIM];
  logic [SIZE_W-1:0] shadow_size;
  row_res_t          pending_results [$];
  int                mismatches;
  int                idle_pct;

  matrix_row_operation_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_row_a        (in_row_a),
    .in_row_b        (in_row_b),
    .in_column       (in_column),
    .in_scalar       (in_scalar),
    .in_element_in   (in_element_in),
    .cfg_we          (cfg_we),
    .cfg_matrix_size (cfg_matrix_size),
    .out_valid       (out_valid),
    .out_element_out (out_element_out),
    .out_status      (out_status),
    .out_saturated   (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("matrix_row_operation_engine: mismatch");
    $finish;
  end

  function automatic logic [DATA_W-1:0] clamp32(longint v, inout logic flag);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      flag = 1'b1;
      return Q_MAX;
    end
    if (v < -longint'(64'sh8000_0000)) begin
      flag = 1'b1;
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // exact 64-bit product, arithmetic shift drops the fraction toward minus infinity
  function automatic logic [DATA_W-1:0] q_mul(logic [DATA_W-1:0] k, logic [DATA_W-1:0] x,
                                              inout logic flag);
    longint prod;
    prod = longint'($signed(k)) * longint'($signed(x));
    return clamp32(prod >>> FRAC_W, flag);
  endfunction

  function automatic row_res_t run_command(row_cmd_t c);
    row_res_t          r;
    int unsigned       n;
    logic              sat;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] t;
    logic [IDX_W-1:0]  mc;
    longint            s;
    r   = '0;
    sat = 1'b0;
    n   = (shadow_size > DIM) ? DIM : shadow_size;
    case (c.cmd) inside
      CMD_LOAD, CMD_READ: begin
        if (c.ra >= n || c.col >= n) r.status = ST_RANGE;
        else if (c.cmd == CMD_LOAD) shadow_matrix[{c.ra, c.col}] = c.elem;
        else r.value = shadow_matrix[{c.ra, c.col}];
      end
      CMD_SCALE: begin
        if (c.ra >= n) r.status = ST_RANGE;
        else for (int m = 0; m < n; m++) begin
          mc = m[IDX_W-1:0];
          shadow_matrix[{c.ra, mc}] = q_mul(c.k, shadow_matrix[{c.ra, mc}], sat);
        end
      end
      CMD_ADD: begin
        if (c.ra >= n || c.rb >= n) r.status = ST_RANGE;
        else for (int m = 0; m < n; m++) begin
          mc = m[IDX_W-1:0];
          p = q_mul(c.k, shadow_matrix[{c.rb, mc}], sat);
          s = longint'($signed(shadow_matrix[{c.ra, mc}])) + longint'($signed(p));
          shadow_matrix[{c.ra, mc}] = clamp32(s, sat);
        end
      end
      CMD_SWAP: begin
        if (c.ra >= n || c.rb >= n) r.status = ST_RANGE;
        else for (int m = 0; m < n; m++) begin
          mc = m[IDX_W-1:0];
          t = shadow_matrix[{c.ra, mc}];
          shadow_matrix[{c.ra, mc}] = shadow_matrix[{c.rb, mc}];
          shadow_matrix[{c.rb, mc}] = t;
        end
      end
      default: ;
    endcase
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_elem();
    int v;
    case ($urandom_range(7)) inside
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_NEG_ONE;
      4, 5: begin
        v = int'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    int v;
    case ($urandom_range(7)) inside
      0: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          default: return Q_ONE;
        endcase
      end
      // near unity keeps values from pinning at the rails
      1, 2, 3, 4: begin
        v = int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index(int unsigned n);
    if (n == 0 || $urandom_range(9) == 0) return IDX_W'($urandom_range(DIM-1));
    return IDX_W'($urandom_range(n-1));
  endfunction

  function automatic row_cmd_t rand_command();
    row_cmd_t    c;
    int unsigned n;
    int unsigned pick;
    n      = (shadow_size > DIM) ? DIM : shadow_size;
    pick   = $urandom_range(99);
    c.ra   = rand_index(n);
    c.rb   = rand_index(n);
    c.col  = rand_index(n);
    c.k    = rand_gain();
    c.elem = rand_elem();
    if (pick < 25)      c.cmd = CMD_LOAD;
    else if (pick < 45) c.cmd = CMD_READ;
    else if (pick < 63) c.cmd = CMD_SCALE;
    else if (pick < 81) c.cmd = CMD_ADD;
    else if (pick < 95) c.cmd = CMD_SWAP;
    else c.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    return c;
  endfunction

  task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("error: %s got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // entered and left at a falling edge; the expectation is queued at the falling
  // edge after the transfer, before any result can show up
  task automatic send_command(row_cmd_t c, logic typed, row_res_t typed_res);
    row_res_t r;
    in_command    <= c.cmd;
    in_row_a      <= c.ra;
    in_row_b      <= c.rb;
    in_column     <= c.col;
    in_scalar     <= c.k;
    in_element_in <= c.elem;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    r = run_command(c);
    @(negedge clk);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic sender_gap();
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] sz);
    drain();
    repeat (4) @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_matrix_size <= sz;
    @(negedge clk);
    cfg_we      <= 1'b0;
    shadow_size  = sz;
  endtask

  always @(posedge clk) begin
    row_res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with none expected", out_element_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_element_out !== want.value)
          flag_mismatch("element_out", out_element_out, want.value);
        if (out_status !== want.status)
          flag_mismatch("status", {31'd0, out_status}, {31'd0, want.status});
        if (out_saturated !== want.sat)
          flag_mismatch("saturated", {31'd0, out_saturated}, {31'd0, want.sat});
      end
    end
  end

  initial begin
    row_cmd_t c;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_LOAD;
    in_row_a        = '0;
    in_row_b        = '0;
    in_column       = '0;
    in_scalar       = '0;
    in_element_in   = '0;
    cfg_we          = 1'b0;
    cfg_matrix_size = SIZE_RESET;
    mismatches      = 0;
    idle_pct        = 0;
    shadow_size     = SIZE_RESET;
    foreach (shadow_matrix[i]) shadow_matrix[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_command(DIR_STEPS[i].c, DIR_STEPS[i].typed, DIR_STEPS[i].r);

    // every element gets written before any random traffic can read it
    write_size(5'd16);
    for (int i = 0; i < DIM*DIM; i++) begin
      c      = '0;
      c.cmd  = CMD_LOAD;
      c.ra   = IDX_W'(i / DIM);
      c.col  = IDX_W'(i % DIM);
      c.elem = rand_elem();
      send_command(c, 1'b0, R_DONE);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_size(PHASE_SIZE[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 64;
        default: idle_pct = 28;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off until the engine has answered everything
        if ((ph == 0 && i == 30) || $urandom_range(63) == 0) drain();
        sender_gap();
        send_command(rand_command(), 1'b0, R_DONE);
      end
    end

    drain();
    repeat (48) @(negedge clk);
    if (mismatches == 0) begin
      $display("matrix_row_operation_engine: match");
    end else begin
      $display("matrix_row_operation_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mroe_pkg.sv
rtl/mroe_mem.sv
rtl/mroe_alu.sv
rtl/mroe_seq.sv
rtl/matrix_row_operation_engine.sv
rtl/mroe_chk.sv
sim/tb.sv
